>>> src/relay_backup_selector_core_defines.svh
// assertion macros for the relay and backup selector
// used by relay_backup_selector_core; needs clk_i and rst_ni in scope
`ifndef RELAY_BACKUP_SELECTOR_CORE_DEFINES_SVH
`define RELAY_BACKUP_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define RBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rbs_pkg.sv
// shared types, codes and widths of the relay and backup selector
// no dependencies; imported by every rbs module and the top level
package rbs_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned EnergyW  = 31;
  localparam int unsigned NodeEW   = 32;
  localparam int unsigned PosW     = 24;
  localparam int unsigned DistW    = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned MulW     = 32;
  localparam int unsigned SqRootW  = 25;
  localparam int unsigned SqInW    = 2 * SqRootW;
  localparam int unsigned DivW     = 64;
  localparam int unsigned DenW     = 50;

  localparam logic signed [DivW-1:0] ScoreMax = {1'b0, {(DivW-1){1'b1}}};
  localparam logic [MulW-1:0] CosLimit = {1'b1, {(MulW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_X    = 3'd0,
    CFG_OWN_Y    = 3'd1,
    CFG_OWN_BS   = 3'd2,
    CFG_CRITICAL = 3'd3,
    CFG_MARGIN   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_ADVERT = 1'b0,
    CMD_REPORT = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    OC_BS      = 3'd0,
    OC_RELAY   = 3'd1,
    OC_BACKUP  = 3'd2,
    OC_REJECT  = 3'd3,
    OC_KEPT    = 3'd4,
    OC_SWAP    = 3'd5,
    OC_SEARCH  = 3'd6
  } outcome_e;

  typedef enum logic [1:0] {
    ND_CAND,
    ND_RELAY,
    ND_BACKUP
  } node_sel_e;

  typedef enum logic [2:0] {
    MS_DX,
    MS_DY,
    MS_DC,
    MS_DB,
    MS_DCB,
    MS_DCB_DB,
    MS_EC
  } mul_sel_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BS,
    OP_REJECT,
    OP_REPORT,
    OP_DELTA,
    OP_MUL,
    OP_ACC_SET,
    OP_ACC_ADD,
    OP_ACC_SUB,
    OP_SQRT_GO,
    OP_DIST,
    OP_DEN,
    OP_DIV1_GO,
    OP_C_TAKE,
    OP_DIV2_GO,
    OP_S_TAKE,
    OP_S_MAX,
    OP_SET_RELAY,
    OP_SET_BACKUP,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic                   command;
    logic                   from_base_station;
    logic [AddrW-1:0]       candidate_addr;
    logic [EnergyW-1:0]     candidate_energy;
    logic signed [PosW-1:0] candidate_x;
    logic signed [PosW-1:0] candidate_y;
    logic [DistW-1:0]       candidate_bs_distance;
    logic [EnergyW-1:0]     consumed_energy;
  } rbs_in_t;

  typedef struct packed {
    logic [AddrW-1:0] next_hop;
    logic [AddrW-1:0] relay_address;
    logic [AddrW-1:0] backup_address;
    logic [2:0]       outcome;
    logic             request_search;
  } rbs_out_t;

  typedef struct packed {
    logic [AddrW-1:0]         addr;
    logic signed [NodeEW-1:0] energy;
    logic [DistW-1:0]         bs_dist;
    logic [DistW-1:0]         hop_dist;
  } rbs_node_t;

  typedef struct packed {
    dp_op_e    op;
    mul_sel_e  msel;
    node_sel_e node;
  } rbs_cmd_t;

  typedef struct packed {
    logic is_report;
    logic from_bs;
    logic bs_known;
    logic relay_empty;
    logic backup_empty;
    logic zero_div;
    logic cand_wins;
    logic sqrt_done;
    logic div_done;
  } rbs_sts_t;

endpackage

>>> src/rbs_sqrt.sv
// iterative integer square root, one result bit per cycle
// depends on rbs_pkg for widths
module rbs_sqrt import rbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SqInW-1:0]   rad_i,
  output logic               done_o,
  output logic [SqRootW-1:0] root_o
);

  localparam int unsigned RemW = SqRootW + 3;
  localparam int unsigned CntW = $clog2(SqRootW + 1);

  logic [SqInW-1:0]   rad_q;
  logic [RemW-1:0]    rem_q;
  logic [SqRootW-1:0] root_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  logic            fits;

  // bring down two radicand bits, try root*4+1
  assign rem_sh = {rem_q[RemW-3:0], rad_q[SqInW-1 -: 2]};
  assign trial  = {{(RemW-SqRootW-2){1'b0}}, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SqRootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SqInW-3:0], 2'b00};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[SqRootW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> src/rbs_div.sv
// unsigned restoring divider, one quotient bit per cycle
// depends on rbs_pkg for widths; shared by both score divisions
module rbs_div import rbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dvd_i,
  input  logic [DivW-1:0] dvs_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] dvd_q;
  logic [DivW-1:0] dvs_q;
  logic [DivW:0]   rem_q;
  logic [DivW-1:0] quot_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DivW:0] rem_sh;
  logic          fits;

  assign rem_sh = {rem_q[DivW-1:0], dvd_q[DivW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dvd_i;
      dvs_q  <= dvs_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
      rem_q  <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quot_q <= {quot_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> src/rbs_dp.sv
// datapath: config registers, node state, shared multiplier, sqrt and divider
// depends on rbs_pkg, rbs_sqrt and rbs_div; driven by rbs_ctrl commands
module rbs_dp import rbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbs_cmd_t            cmd_i,
  output rbs_sts_t            sts_o,
  input  rbs_in_t             in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output rbs_out_t            out_data_o
);

  // configuration
  logic signed [PosW-1:0] own_x_q, own_y_q;
  logic [DistW-1:0]       own_db_q;
  logic [EnergyW-1:0]     crit_q, margin_q;

  // held state
  logic [AddrW-1:0] bs_addr_q;
  rbs_node_t        relay_q, backup_q;
  outcome_e         outcome_q;

  // per-item scratch
  rbs_in_t            in_q;
  logic [DistW-1:0]   cand_dist_q;
  logic [PosW:0]      dxa_q, dya_q;
  logic [DivW-1:0]    p_q;
  logic signed [DivW-1:0] acc_q;
  logic [DenW-1:0]    den_q;
  logic [MulW-1:0]    cmag_q, emag_q;
  logic               pneg_q, dneg_q;
  logic signed [DivW-1:0] sc_cand_q, sc_held_q;
  rbs_out_t           out_q;

  rbs_node_t cand, nd;
  logic signed [PosW:0] dx, dy;
  logic [MulW-1:0] mul_a, mul_b;
  logic [DivW-1:0] mul_p;
  logic [DivW-1:0] acc_mag;
  logic [DivW-1:0] div_dvd, div_dvs;
  logic            div_start, div_done;
  logic [DivW-1:0] div_q;
  logic            sq_done;
  logic [SqRootW-1:0] sq_root;
  logic signed [DivW-1:0] q_signed;

  // energy report
  logic signed [NodeEW+1:0] e_full;
  logic signed [NodeEW-1:0] e_new;
  logic                     e_lt_crit, b_lt_crit, margin_hit;
  logic signed [NodeEW+1:0] lead;
  rbs_node_t                relay_upd;

  always_comb begin
    cand.addr     = in_q.candidate_addr;
    cand.energy   = $signed({1'b0, in_q.candidate_energy});
    cand.bs_dist  = in_q.candidate_bs_distance;
    cand.hop_dist = cand_dist_q;
    unique case (cmd_i.node)
      ND_CAND:   nd = cand;
      ND_RELAY:  nd = relay_q;
      ND_BACKUP: nd = backup_q;
      default:   nd = relay_q;
    endcase
  end

  assign dx = $signed({in_q.candidate_x[PosW-1], in_q.candidate_x})
            - $signed({own_x_q[PosW-1], own_x_q});
  assign dy = $signed({in_q.candidate_y[PosW-1], in_q.candidate_y})
            - $signed({own_y_q[PosW-1], own_y_q});

  always_comb begin
    unique case (cmd_i.msel)
      MS_DX:     begin mul_a = MulW'(dxa_q);       mul_b = MulW'(dxa_q);    end
      MS_DY:     begin mul_a = MulW'(dya_q);       mul_b = MulW'(dya_q);    end
      MS_DC:     begin mul_a = MulW'(nd.hop_dist); mul_b = MulW'(nd.hop_dist); end
      MS_DB:     begin mul_a = MulW'(own_db_q);    mul_b = MulW'(own_db_q); end
      MS_DCB:    begin mul_a = MulW'(nd.bs_dist);  mul_b = MulW'(nd.bs_dist); end
      MS_DCB_DB: begin mul_a = MulW'(nd.bs_dist);  mul_b = MulW'(own_db_q); end
      MS_EC:     begin mul_a = emag_q;             mul_b = cmag_q;          end
      default:   begin mul_a = emag_q;             mul_b = cmag_q;          end
    endcase
  end

  assign mul_p = DivW'(mul_a) * DivW'(mul_b);

  // numerator magnitude, pre-scaled by 8192 for the Q.13 cosine
  assign acc_mag = acc_q[DivW-1] ? DivW'(-acc_q) : DivW'(acc_q);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {acc_mag[DivW-14:0], 13'b0};
    div_dvs   = DivW'(den_q);
    unique case (cmd_i.op)
      OP_DIV1_GO: div_start = 1'b1;
      OP_DIV2_GO: begin
        div_start = 1'b1;
        div_dvd   = p_q;
        div_dvs   = DivW'(nd.bs_dist);
      end
      default: div_start = 1'b0;
    endcase
  end

  rbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  rbs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_SQRT_GO),
    .rad_i   (acc_q[SqInW-1:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign q_signed = dneg_q ? -$signed(div_q) : $signed(div_q);

  assign e_full = $signed({{2{relay_q.energy[NodeEW-1]}}, relay_q.energy})
                - $signed({3'b000, in_q.consumed_energy});
  // saturate at the most negative 32-bit value
  assign e_new  = (e_full[NodeEW+1] && !(&e_full[NodeEW:NodeEW-1]))
                ? {1'b1, {(NodeEW-1){1'b0}}} : e_full[NodeEW-1:0];
  assign e_lt_crit = $signed({e_new[NodeEW-1], e_new}) < $signed({2'b00, crit_q});
  assign b_lt_crit = $signed({backup_q.energy[NodeEW-1], backup_q.energy})
                   < $signed({2'b00, crit_q});
  assign lead = $signed({{2{backup_q.energy[NodeEW-1]}}, backup_q.energy})
              - $signed({{2{e_new[NodeEW-1]}}, e_new});
  assign margin_hit = lead >= $signed({3'b000, margin_q});

  // relay after the report is charged
  always_comb begin
    relay_upd        = relay_q;
    relay_upd.energy = e_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_x_q   <= '0;
      own_y_q   <= '0;
      own_db_q  <= '0;
      crit_q    <= '0;
      margin_q  <= '0;
      bs_addr_q <= '0;
      relay_q   <= '0;
      backup_q  <= '0;
      outcome_q <= OC_BS;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_OWN_X:    own_x_q  <= cfg_wdata_i[PosW-1:0];
          CFG_OWN_Y:    own_y_q  <= cfg_wdata_i[PosW-1:0];
          CFG_OWN_BS:   own_db_q <= cfg_wdata_i[DistW-1:0];
          CFG_CRITICAL: crit_q   <= cfg_wdata_i[EnergyW-1:0];
          CFG_MARGIN:   margin_q <= cfg_wdata_i[EnergyW-1:0];
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        OP_BS: begin
          bs_addr_q <= in_q.candidate_addr;
          outcome_q <= OC_BS;
        end
        OP_REJECT: outcome_q <= OC_REJECT;
        OP_SET_RELAY: begin
          relay_q   <= cand;
          outcome_q <= OC_RELAY;
        end
        OP_SET_BACKUP: begin
          backup_q  <= cand;
          outcome_q <= OC_BACKUP;
        end
        OP_REPORT: begin
          if (e_lt_crit && b_lt_crit) begin
            relay_q   <= relay_upd;
            outcome_q <= OC_SEARCH;
          end else if (e_lt_crit || margin_hit) begin
            relay_q   <= backup_q;
            backup_q  <= relay_upd;
            outcome_q <= OC_SWAP;
          end else begin
            relay_q   <= relay_upd;
            outcome_q <= OC_KEPT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD:    in_q <= in_data_i;
      OP_DELTA: begin
        dxa_q <= dx[PosW] ? (PosW+1)'(-dx) : (PosW+1)'(dx);
        dya_q <= dy[PosW] ? (PosW+1)'(-dy) : (PosW+1)'(dy);
      end
      OP_MUL:     p_q   <= mul_p;
      OP_ACC_SET: acc_q <= $signed(p_q);
      OP_ACC_ADD: acc_q <= acc_q + $signed(p_q);
      OP_ACC_SUB: acc_q <= acc_q - $signed(p_q);
      OP_DIST:    cand_dist_q <= sq_root[SqRootW-1] ? {DistW{1'b1}} : sq_root[DistW-1:0];
      OP_DEN:     den_q <= {p_q[DenW-2:0], 1'b0};
      OP_DIV1_GO: dneg_q <= acc_q[DivW-1];
      OP_C_TAKE: begin
        cmag_q <= (div_q > DivW'(CosLimit)) ? CosLimit : div_q[MulW-1:0];
        emag_q <= nd.energy[NodeEW-1] ? MulW'(-nd.energy) : MulW'(nd.energy);
        pneg_q <= dneg_q ^ nd.energy[NodeEW-1];
      end
      OP_DIV2_GO: dneg_q <= pneg_q;
      OP_S_TAKE: begin
        if (cmd_i.node == ND_CAND) sc_cand_q <= q_signed;
        else                       sc_held_q <= q_signed;
      end
      OP_S_MAX: begin
        if (cmd_i.node == ND_CAND) sc_cand_q <= ScoreMax;
        else                       sc_held_q <= ScoreMax;
      end
      OP_EMIT: begin
        out_q.next_hop       <= (bs_addr_q != '0) ? bs_addr_q : relay_q.addr;
        out_q.relay_address  <= relay_q.addr;
        out_q.backup_address <= backup_q.addr;
        out_q.outcome        <= outcome_q;
        out_q.request_search <= outcome_q == OC_SEARCH;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.is_report    = in_q.command == CMD_REPORT;
    sts_o.from_bs      = in_q.from_base_station;
    sts_o.bs_known     = bs_addr_q != '0;
    sts_o.relay_empty  = relay_q.addr == '0;
    sts_o.backup_empty = backup_q.addr == '0;
    sts_o.zero_div     = (nd.bs_dist == '0) || (own_db_q == '0);
    sts_o.cand_wins    = sc_cand_q > sc_held_q;
    sts_o.sqrt_done    = sq_done;
    sts_o.div_done     = div_done;
  end

  assign out_data_o = out_q;

endmodule

>>> src/rbs_ctrl.sv
// controller: sequences one item at a time through the datapath
// depends on rbs_pkg; drives rbs_dp through rbs_cmd_t, reads rbs_sts_t
module rbs_ctrl import rbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  rbs_sts_t sts_i,
  output rbs_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISPATCH, ST_REPORT, ST_BS, ST_REJECT, ST_DELTA,
    ST_MX, ST_AX, ST_MY, ST_AY, ST_SQ_GO, ST_SQ_WAIT, ST_SQ_TAKE,
    ST_SC_START, ST_SC_MAX, ST_M1, ST_A1, ST_M2, ST_A2, ST_M3, ST_A3,
    ST_M4, ST_DEN, ST_D1_GO, ST_D1_WAIT, ST_C_TAKE, ST_M5, ST_D2_GO,
    ST_D2_WAIT, ST_S_TAKE, ST_SC_RET, ST_SET_R, ST_SET_B, ST_FINISH
  } state_e;

  state_e    state_q;
  node_sel_e node_q;
  logic      out_valid_q;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_q      <= ND_CAND;
      out_valid_q <= 1'b0;
    end else begin
      // finish state loads or holds the output register itself
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE:     if (in_valid_i) state_q <= ST_DISPATCH;
        ST_DISPATCH: begin
          priority if (sts_i.is_report) state_q <= ST_REPORT;
          else if (sts_i.from_bs)       state_q <= ST_BS;
          else if (sts_i.bs_known)      state_q <= ST_REJECT;
          else                          state_q <= ST_DELTA;
        end
        ST_REPORT:  state_q <= ST_FINISH;
        ST_BS:      state_q <= ST_FINISH;
        ST_REJECT:  state_q <= ST_FINISH;
        ST_DELTA:   state_q <= ST_MX;
        ST_MX:      state_q <= ST_AX;
        ST_AX:      state_q <= ST_MY;
        ST_MY:      state_q <= ST_AY;
        ST_AY:      state_q <= ST_SQ_GO;
        ST_SQ_GO:   state_q <= ST_SQ_WAIT;
        ST_SQ_WAIT: if (sts_i.sqrt_done) state_q <= ST_SQ_TAKE;
        ST_SQ_TAKE: begin
          node_q  <= ND_CAND;
          state_q <= ST_SC_START;
        end
        ST_SC_START: begin
          // first candidate needs no score
          priority if (node_q == ND_CAND && sts_i.relay_empty) state_q <= ST_SET_R;
          else if (sts_i.zero_div) state_q <= ST_SC_MAX;
          else                     state_q <= ST_M1;
        end
        ST_SC_MAX:  state_q <= ST_SC_RET;
        ST_M1:      state_q <= ST_A1;
        ST_A1:      state_q <= ST_M2;
        ST_M2:      state_q <= ST_A2;
        ST_A2:      state_q <= ST_M3;
        ST_M3:      state_q <= ST_A3;
        ST_A3:      state_q <= ST_M4;
        ST_M4:      state_q <= ST_DEN;
        ST_DEN:     state_q <= ST_D1_GO;
        ST_D1_GO:   state_q <= ST_D1_WAIT;
        ST_D1_WAIT: if (sts_i.div_done) state_q <= ST_C_TAKE;
        ST_C_TAKE:  state_q <= ST_M5;
        ST_M5:      state_q <= ST_D2_GO;
        ST_D2_GO:   state_q <= ST_D2_WAIT;
        ST_D2_WAIT: if (sts_i.div_done) state_q <= ST_S_TAKE;
        ST_S_TAKE:  state_q <= ST_SC_RET;
        ST_SC_RET: begin
          unique case (node_q)
            ND_CAND: begin
              node_q  <= ND_RELAY;
              state_q <= ST_SC_START;
            end
            ND_RELAY: begin
              priority if (sts_i.cand_wins) state_q <= ST_SET_R;
              else if (sts_i.backup_empty)  state_q <= ST_SET_B;
              else begin
                node_q  <= ND_BACKUP;
                state_q <= ST_SC_START;
              end
            end
            default: state_q <= sts_i.cand_wins ? ST_SET_B : ST_REJECT;
          endcase
        end
        ST_SET_R:  state_q <= ST_FINISH;
        ST_SET_B:  state_q <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.msel = MS_DX;
    cmd_o.node = node_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_REPORT:  cmd_o.op = OP_REPORT;
      ST_BS:      cmd_o.op = OP_BS;
      ST_REJECT:  cmd_o.op = OP_REJECT;
      ST_DELTA:   cmd_o.op = OP_DELTA;
      ST_MX:      cmd_o.op = OP_MUL;
      ST_AX:      cmd_o.op = OP_ACC_SET;
      ST_MY:      begin cmd_o.op = OP_MUL; cmd_o.msel = MS_DY; end
      ST_AY:      cmd_o.op = OP_ACC_ADD;
      ST_SQ_GO:   cmd_o.op = OP_SQRT_GO;
      ST_SQ_TAKE: cmd_o.op = OP_DIST;
      ST_SC_MAX:  cmd_o.op = OP_S_MAX;
      ST_M1:      begin cmd_o.op = OP_MUL; cmd_o.msel = MS_DC; end
      ST_A1:      cmd_o.op = OP_ACC_SET;
      ST_M2:      begin cmd_o.op = OP_MUL; cmd_o.msel = MS_DB; end
      ST_A2:      cmd_o.op = OP_ACC_ADD;
      ST_M3:      begin cmd_o.op = OP_MUL; cmd_o.msel = MS_DCB; end
      ST_A3:      cmd_o.op = OP_ACC_SUB;
      ST_M4:      begin cmd_o.op = OP_MUL; cmd_o.msel = MS_DCB_DB; end
      ST_DEN:     cmd_o.op = OP_DEN;
      ST_D1_GO:   cmd_o.op = OP_DIV1_GO;
      ST_C_TAKE:  cmd_o.op = OP_C_TAKE;
      ST_M5:      begin cmd_o.op = OP_MUL; cmd_o.msel = MS_EC; end
      ST_D2_GO:   cmd_o.op = OP_DIV2_GO;
      ST_S_TAKE:  cmd_o.op = OP_S_TAKE;
      ST_SET_R:   cmd_o.op = OP_SET_RELAY;
      ST_SET_B:   cmd_o.op = OP_SET_BACKUP;
      ST_FINISH:  if (out_free) cmd_o.op = OP_EMIT;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

>>> src/relay_backup_selector_core.sv
// Relay and backup selector. One beat in gives one beat out. An energy report,
// a base station advert or a rejected advert passes from dispatch through one action
// state to the finish state. A scored advert runs a 25-step square root for the
// candidate distance and then up to three scores, each of which drives the shared
// 64-step divider twice unless a base station distance is zero. One item is in
// flight at a time; the result sits in an output register, a result still stalled
// there holds the next item at its last step, and the block is ready again as soon
// as that register is loaded.
`include "relay_backup_selector_core_defines.svh"

module relay_backup_selector_core import rbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rbs_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rbs_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  rbs_cmd_t cmd;
  rbs_sts_t sts;

  rbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

  `RBS_ASSERT_NOW(a_search_flag, out_valid_o,
    out_data_o.request_search == (out_data_o.outcome == OC_SEARCH),
    "search flag disagrees with outcome")
  `RBS_ASSERT_NEXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o,
    "input taken while an item is in flight")
  `RBS_ASSERT_NOW(a_result_from_item, $rose(out_valid_o), $past(in_stall_o),
    "result appeared with no item in flight")

endmodule
